@@ rtl/los_pkg.sv @@
package los_pkg;

    localparam int CW = 5;
    localparam int MAX_RESULTS = 63;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PW = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 2;
    localparam int RES_PW = $clog2(RES_DEPTH);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TRACE = 1'b1;

    typedef struct packed {
        logic                 is_trace;
        logic [CW-1:0]        x0;
        logic [CW-1:0]        y0;
        logic [CW-1:0]        x1;
        logic [CW-1:0]        y1;
        logic                 opq;
        logic signed [CW:0]   dx;
        logic signed [CW:0]   dy;
        logic                 sx_neg;
        logic                 sy_neg;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0] cell_x;
        logic [CW-1:0] cell_y;
        logic          blocked;
        logic          last;
    } t_res;

endpackage

@@ rtl/line_of_sight_ray_walk.sv @@
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------------
// request   | in        | push / full                | kind pos_x pos_y end_x end_y opaque_bit
// result    | out       | empty / pop                | cell_x cell_y blocked last
//
// A map write is done in the walker when the request is taken. A trace is loaded, then walks
// one result cell per step; the map read lags the walker, so an opaque cell is found behind it.
// After reset the map is swept clear, one bit per cycle; requests
// queue meanwhile and are not started until the sweep ends.
// A two-entry request queue and a two-entry result queue let each side stall independently;
// a full result queue freezes the walk in place.
module line_of_sight_ray_walk #(
    parameter int MAP_SIDE = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [4:0] i_pos_x,
    input  logic [4:0] i_pos_y,
    input  logic [4:0] i_end_x,
    input  logic [4:0] i_end_y,
    input  logic       i_opaque_bit,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] o_cell_x,
    output logic [4:0] o_cell_y,
    output logic       o_blocked,
    output logic       o_last
);
    import los_pkg::*;

    logic w_cmd_valid, w_take, w_oq_full, w_oq_push;
    t_cmd w_cmd;
    t_res w_res;

    los_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_kind       (i_kind),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_opaque_bit (i_opaque_bit),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_take       (w_take)
    );

    los_walk #(
        .MAP_SIDE (MAP_SIDE)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_take      (w_take),
        .i_oq_full   (w_oq_full),
        .o_oq_push   (w_oq_push),
        .o_res       (w_res)
    );

    los_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_oq_push),
        .i_res     (w_res),
        .o_full    (w_oq_full),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_cell_x  (o_cell_x),
        .o_cell_y  (o_cell_y),
        .o_blocked (o_blocked),
        .o_last    (o_last)
    );

endmodule

@@ rtl/los_front.sv @@
module los_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_kind,
    input  logic [4:0]    i_pos_x,
    input  logic [4:0]    i_pos_y,
    input  logic [4:0]    i_end_x,
    input  logic [4:0]    i_end_y,
    input  logic          i_opaque_bit,
    output logic          o_cmd_valid,
    output los_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    import los_pkg::*;

    t_cmd              r_q [CMD_DEPTH];
    logic [CMD_PW-1:0] r_wp, n_wp;
    logic [CMD_PW-1:0] r_rp, n_rp;
    logic [CMD_PW:0]   r_cnt, n_cnt;
    t_cmd              w_cmd;
    logic              w_wr;
    logic              w_rd;

    // classify and precompute walk deltas on entry
    always_comb begin
        w_cmd.is_trace = (i_kind == KIND_TRACE);
        w_cmd.x0       = i_pos_x;
        w_cmd.y0       = i_pos_y;
        w_cmd.x1       = i_end_x;
        w_cmd.y1       = i_end_y;
        w_cmd.opq      = i_opaque_bit;
        w_cmd.dx       = $signed({1'b0, i_end_x}) - $signed({1'b0, i_pos_x});
        w_cmd.dy       = $signed({1'b0, i_end_y}) - $signed({1'b0, i_pos_y});
        w_cmd.sx_neg   = !(i_pos_x < i_end_x);
        w_cmd.sy_neg   = !(i_pos_y < i_end_y);
    end

    assign o_full      = (r_cnt == (CMD_PW+1)'(CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_take && o_cmd_valid;

    always_comb begin
        n_wp  = w_wr ? r_wp + 1'b1 : r_wp;
        n_rp  = w_rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

@@ rtl/los_walk.sv @@
module los_walk #(
    parameter int MAP_SIDE = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  los_pkg::t_cmd i_cmd,
    output logic          o_take,
    input  logic          i_oq_full,
    output logic          o_oq_push,
    output los_pkg::t_res o_res
);
    import los_pkg::*;

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW = $clog2(DEPTH);
    localparam int EW = 12;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic           r_map [DEPTH];
    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;

    // walker cell
    logic [CW-1:0]       r_x, n_x, r_y, n_y, r_x1, n_x1, r_y1, n_y1;
    logic signed [CW:0]  r_dx, n_dx, r_dy, n_dy;
    logic                r_sxn, n_sxn, r_syn, n_syn;
    logic signed [EW-1:0] r_e, n_e;
    logic [10:0]         r_d2, n_d2;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // lookup stage, aligned with the map read data
    logic           r_pv, n_pv;
    logic [CW-1:0]  r_px, n_px, r_py, n_py;
    logic           r_pend, n_pend;
    logic           r_pin, n_pin;
    logic           r_rd;

    logic            w_adv, w_abort, w_at_end, w_in_map, w_blk;
    logic            w_step_x, w_step_y;
    logic signed [EW-1:0] w_dyt, w_dxt, w_e1, w_e2, w_ed;
    logic signed [23:0]   w_sq1, w_sq2;
    logic signed [11:0]   w_dx2, w_dy2;
    logic            w_we, w_wbit, w_win;
    logic [AW-1:0]   w_waddr, w_raddr;

    assign w_adv    = !r_pv || !i_oq_full;
    assign o_take   = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_at_end = ((r_x == r_x1) && (r_y == r_y1)) ||
                      (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign w_in_map = ({1'b0, r_x} < (CW+1)'(MAP_SIDE)) &&
                      ({1'b0, r_y} < (CW+1)'(MAP_SIDE));
    assign w_raddr  = AW'(int'(r_y) * MAP_SIDE + int'(r_x));

    assign w_blk     = !r_pend && r_pin && r_rd;
    assign o_oq_push = r_pv && !i_oq_full;
    assign w_abort   = o_oq_push && w_blk;
    always_comb begin
        o_res.cell_x  = r_px;
        o_res.cell_y  = r_py;
        o_res.blocked = w_blk;
        o_res.last    = r_pend || w_blk;
    end

    // e tracks dy*(x-x0) - dx*(y-y0) at the current cell
    assign w_dyt = r_sxn ? -EW'(r_dy) : EW'(r_dy);
    assign w_dxt = r_syn ? EW'(r_dx) : -EW'(r_dx);
    assign w_e1  = r_e + w_dyt;
    assign w_e2  = r_e + w_dxt;
    assign w_ed  = w_e1 + w_dxt;
    assign w_sq1 = 24'(w_e1) * 24'(w_e1);
    assign w_sq2 = 24'(w_e2) * 24'(w_e2);
    assign w_step_x = ({w_sq1, 2'b00} < 26'(r_d2));
    assign w_step_y = !w_step_x && ({w_sq2, 2'b00} < 26'(r_d2));

    assign w_dx2 = 12'(i_cmd.dx) * 12'(i_cmd.dx);
    assign w_dy2 = 12'(i_cmd.dy) * 12'(i_cmd.dy);

    assign w_win   = ({1'b0, i_cmd.x0} < (CW+1)'(MAP_SIDE)) &&
                     ({1'b0, i_cmd.y0} < (CW+1)'(MAP_SIDE));
    assign w_we    = (r_state == ST_CLR) || (o_take && !i_cmd.is_trace && w_win);
    assign w_wbit  = (r_state == ST_CLR) ? 1'b0 : i_cmd.opq;
    assign w_waddr = (r_state == ST_CLR) ? r_clr :
                     AW'(int'(i_cmd.y0) * MAP_SIDE + int'(i_cmd.x0));

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_x = r_x; n_y = r_y; n_x1 = r_x1; n_y1 = r_y1;
        n_dx = r_dx; n_dy = r_dy; n_sxn = r_sxn; n_syn = r_syn;
        n_e = r_e; n_d2 = r_d2; n_cnt = r_cnt;
        n_pv = r_pv; n_px = r_px; n_py = r_py; n_pend = r_pend; n_pin = r_pin;

        if (w_adv) begin
            n_pv   = (r_state == ST_WALK) && !w_abort;
            n_px   = w_at_end ? r_x1 : r_x;
            n_py   = w_at_end ? r_y1 : r_y;
            n_pend = w_at_end;
            n_pin  = w_in_map;
        end

        unique case (r_state)
            ST_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_take && i_cmd.is_trace) begin
                    n_state = ST_WALK;
                    n_x   = i_cmd.x0;
                    n_y   = i_cmd.y0;
                    n_x1  = i_cmd.x1;
                    n_y1  = i_cmd.y1;
                    n_dx  = i_cmd.dx;
                    n_dy  = i_cmd.dy;
                    n_sxn = i_cmd.sx_neg;
                    n_syn = i_cmd.sy_neg;
                    n_e   = '0;
                    n_cnt = '0;
                    n_d2  = 11'(w_dx2 + w_dy2);
                end
            end
            ST_WALK: begin
                if (w_adv) begin
                    if (w_abort || w_at_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        if (!w_step_y) begin
                            n_x = r_sxn ? r_x - 1'b1 : r_x + 1'b1;
                        end
                        if (!w_step_x) begin
                            n_y = r_syn ? r_y - 1'b1 : r_y + 1'b1;
                        end
                        n_e = w_step_x ? w_e1 : (w_step_y ? w_e2 : w_ed);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_x1 <= n_x1; r_y1 <= n_y1;
        r_dx <= n_dx; r_dy <= n_dy; r_sxn <= n_sxn; r_syn <= n_syn;
        r_e <= n_e; r_d2 <= n_d2; r_cnt <= n_cnt;
        r_px <= n_px; r_py <= n_py; r_pend <= n_pend; r_pin <= n_pin;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wbit;
        end
    end

    // read held while the lookup stage stalls
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd <= r_map[w_raddr];
        end
    end

    a_abort_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_abort |=> !r_pv)
        else $error("lookup stage not flushed after blocked cell");

    a_take_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (!r_pv || r_pend))
        else $error("new request taken behind a testable cell");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && !w_adv) |=> ($stable(r_rd) && $stable(r_px) && $stable(r_py)))
        else $error("lookup stage changed while stalled");

    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && w_adv && !w_abort && !w_at_end) |=>
        (r_x != $past(r_x) || r_y != $past(r_y)))
        else $error("walk step did not move");

endmodule

@@ rtl/los_outq.sv @@
module los_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  los_pkg::t_res i_res,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [4:0]    o_cell_x,
    output logic [4:0]    o_cell_y,
    output logic          o_blocked,
    output logic          o_last
);
    import los_pkg::*;

    t_res              r_q [RES_DEPTH];
    logic [RES_PW-1:0] r_wp, r_rp;
    logic [RES_PW:0]   r_cnt, n_cnt;
    logic              w_wr, w_rd;
    t_res              w_head;

    assign o_full  = (r_cnt == (RES_PW+1)'(RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign w_head  = r_q[r_rp];

    assign o_cell_x  = w_head.cell_x;
    assign o_cell_y  = w_head.cell_y;
    assign o_blocked = w_head.blocked;
    assign o_last    = w_head.last;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    import los_pkg::*;

    localparam int SIDE = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 370;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES = 300;

    // Opacity map copy plus the queue of cells each trace should produce.
    class los_scoreboard;
        bit   opacity [SIDE*SIDE];
        t_res cell_q [$];
        int   errors;

        function void note_request(logic kind, logic [4:0] px, logic [4:0] py,
                                   logic [4:0] ex, logic [4:0] ey, logic ob);
            int x0, y0, x1, y1, dx, dy, sx, sy, d2, x, y, e1, e2, n;
            if (kind == KIND_WRITE) begin
                if (px < SIDE && py < SIDE)
                    opacity[py * SIDE + px] = ob;
                return;
            end
            x0 = px;
            y0 = py;
            x1 = ex;
            y1 = ey;
            dx = x1 - x0;
            dy = y1 - y0;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            d2 = dx * dx + dy * dy;
            x = x0;
            y = y0;
            n = 0;
            while ((x != x1 || y != y1) && n < MAX_RESULTS - 1) begin
                if (x >= 0 && y >= 0 && x < SIDE && y < SIDE && opacity[y * SIDE + x]) begin
                    cell_q.push_back(t_res'{x[4:0], y[4:0], 1'b1, 1'b1});
                    return;
                end
                cell_q.push_back(t_res'{x[4:0], y[4:0], 1'b0, 1'b0});
                n++;
                // pick the neighbor whose center stays within half a cell of the line
                e1 = dy * (x - x0 + sx) - dx * (y - y0);
                e2 = dy * (x - x0) - dx * (y - y0 + sy);
                if (4 * e1 * e1 < d2) begin
                    x += sx;
                end else if (4 * e2 * e2 < d2) begin
                    y += sy;
                end else begin
                    x += sx;
                    y += sy;
                end
            end
            // end cell is never tested for opacity
            cell_q.push_back(t_res'{x1[4:0], y1[4:0], 1'b0, 1'b1});
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (cell_q.size() == 0) begin
                $error("unexpected result cell (%0d,%0d)", got.cell_x, got.cell_y);
                errors++;
                return;
            end
            want = cell_q.pop_front();
            if (got.cell_x !== want.cell_x) begin
                $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
                errors++;
            end
            if (got.cell_y !== want.cell_y) begin
                $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
                errors++;
            end
            if (got.blocked !== want.blocked) begin
                $error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int waiting();
            return cell_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic       i_kind;
    logic [4:0] i_pos_x;
    logic [4:0] i_pos_y;
    logic [4:0] i_end_x;
    logic [4:0] i_end_y;
    logic       i_opaque_bit;
    logic       empty;
    logic       pop;
    logic [4:0] o_cell_x;
    logic [4:0] o_cell_y;
    logic       o_blocked;
    logic       o_last;

    los_scoreboard sb = new;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int seen_seq = 0;
    int hold_left = 0;
    int cycle_count = 0;

    line_of_sight_ray_walk #(.MAP_SIDE(SIDE)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_opaque_bit (i_opaque_bit),
        .empty        (empty),
        .pop          (pop),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_blocked    (o_blocked),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_kind = KIND_WRITE;
        i_pos_x = '0;
        i_pos_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        i_opaque_bit = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random pop, with a long hold-off on request from the main flow
    always @(negedge i_clk) begin
        if (hold_seq != seen_seq) begin
            seen_seq = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(t_res'{o_cell_x, o_cell_y, o_blocked, o_last});
    end

    // push stays high from one request to the next unless the sender idles
    task automatic send_req(logic kind, logic [4:0] px, logic [4:0] py,
                            logic [4:0] ex, logic [4:0] ey, logic ob);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_kind <= kind;
        i_pos_x <= px;
        i_pos_y <= py;
        i_end_x <= ex;
        i_end_y <= ey;
        i_opaque_bit <= ob;
        do
            @(posedge i_clk);
        while (full);
        sb.note_request(kind, px, py, ex, ey, ob);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        logic kind;
        int   px, py, ex, ey;
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(99) < 30) ? KIND_WRITE : KIND_TRACE;
            px = $urandom_range(31);
            py = $urandom_range(31);
            if ($urandom_range(3) == 0) begin
                // short trace around the start cell
                ex = px + int'($urandom_range(8)) - 4;
                ey = py + int'($urandom_range(8)) - 4;
                ex = (ex < 0) ? 0 : (ex > 31) ? 31 : ex;
                ey = (ey < 0) ? 0 : (ey > 31) ? 31 : ey;
            end else begin
                ex = $urandom_range(31);
                ey = $urandom_range(31);
            end
            send_req(kind, px[4:0], py[4:0], ex[4:0], ey[4:0], 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 21;
        rx_idle_pct = 49;

        // empty map: diagonals, axes, shallow and steep lines, start equal to end
        send_req(KIND_TRACE, 5'd0, 5'd0, 5'd31, 5'd31, 1'b1);
        send_req(KIND_TRACE, 5'd31, 5'd31, 5'd0, 5'd0, 1'b0);
        send_req(KIND_TRACE, 5'd0, 5'd31, 5'd31, 5'd0, 1'b0);
        send_req(KIND_TRACE, 5'd31, 5'd0, 5'd0, 5'd31, 1'b1);
        send_req(KIND_TRACE, 5'd5, 5'd5, 5'd5, 5'd5, 1'b0);
        send_req(KIND_TRACE, 5'd0, 5'd0, 5'd31, 5'd0, 1'b0);
        send_req(KIND_TRACE, 5'd31, 5'd31, 5'd31, 5'd0, 1'b0);
        send_req(KIND_TRACE, 5'd3, 5'd7, 5'd28, 5'd12, 1'b0);
        send_req(KIND_TRACE, 5'd20, 5'd2, 5'd14, 5'd30, 1'b1);
        // writes carry junk end fields, which must be ignored
        send_req(KIND_WRITE, 5'd10, 5'd10, 5'd31, 5'd31, 1'b1);
        send_req(KIND_WRITE, 5'd31, 5'd31, 5'd17, 5'd9, 1'b1);
        send_req(KIND_WRITE, 5'd0, 5'd0, 5'd31, 5'd0, 1'b1);
        // opaque start, opaque mid-line, opaque end (never tested)
        send_req(KIND_TRACE, 5'd0, 5'd0, 5'd31, 5'd31, 1'b0);
        send_req(KIND_TRACE, 5'd5, 5'd5, 5'd31, 5'd31, 1'b0);
        send_req(KIND_TRACE, 5'd20, 5'd20, 5'd31, 5'd31, 1'b1);
        send_req(KIND_TRACE, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
        // clear a bit again and retrace
        send_req(KIND_WRITE, 5'd10, 5'd10, 5'd0, 5'd0, 1'b0);
        send_req(KIND_TRACE, 5'd5, 5'd5, 5'd31, 5'd31, 1'b0);
        send_req(KIND_WRITE, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
        send_req(KIND_WRITE, 5'd31, 5'd31, 5'd31, 5'd31, 1'b0);
        send_req(KIND_TRACE, 5'd31, 5'd31, 5'd0, 5'd0, 1'b0);
        wait_drained();

        run_random(RANDOM_ITEMS / 3);
        wait_drained();

        tx_idle_pct = 49;
        rx_idle_pct = 21;
        run_random(RANDOM_ITEMS / 3);
        wait_drained();

        // no idling; receiver stops long enough for the block to back up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len = HOLD_CYCLES;
        hold_seq++;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ line_of_sight_ray_walk.f @@
rtl/los_pkg.sv
rtl/los_front.sv
rtl/los_walk.sv
rtl/los_outq.sv
rtl/line_of_sight_ray_walk.sv
bench/testbench.sv
